/* hw/rtl/ppo_pkg.sv */
// ----------------------------------------------------------------------------
// ppo_pkg
// types, codes and stage words shared by the pixel point operation unit
// ----------------------------------------------------------------------------
`default_nettype none

package ppo_pkg;

  localparam int PixW   = 8;
  localparam int LevelW = 10;
  localparam int IdxW   = 3;
  localparam int CfgW   = 10;
  localparam int SqW    = 2 * PixW;
  localparam int SqSumW = SqW + 2;
  localparam int LvlSqW = 2 * LevelW;
  localparam int SumW   = PixW + 2;
  localparam int Div3W  = 20;

  localparam logic [PixW-1:0] PIX_MAX = 8'd255;
  // floor(x / 3) == (x * 683) >> 11 for every x below 1024
  localparam logic [SumW-1:0] DIV3_MUL   = 10'd683;
  localparam int              DIV3_SHIFT = 11;

  typedef enum logic [3:0] {
    MODE_THR       = 4'd0,
    MODE_BAND      = 4'd1,
    MODE_INV_GRAY  = 4'd2,
    MODE_ADD_GRAY  = 4'd3,
    MODE_INV_COLOR = 4'd4,
    MODE_ADD_COLOR = 4'd5,
    MODE_TO_GRAY   = 4'd6,
    MODE_L1        = 4'd7,
    MODE_L2        = 4'd8
  } mode_t;

  typedef enum logic [IdxW-1:0] {
    REG_MODE    = 3'd0,
    REG_LEVEL_A = 3'd1,
    REG_LEVEL_B = 3'd2,
    REG_COLOR_R = 3'd3,
    REG_COLOR_G = 3'd4,
    REG_COLOR_B = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [PixW-1:0] red_in;
    logic [PixW-1:0] green_in;
    logic [PixW-1:0] blue_in;
    logic [PixW-1:0] gray_in;
    logic            frame_end_in;
  } pixel_t;

  typedef struct packed {
    logic [PixW-1:0] red_out;
    logic [PixW-1:0] green_out;
    logic [PixW-1:0] blue_out;
    logic [PixW-1:0] gray_out;
    logic            frame_end_out;
  } result_t;

  typedef struct packed {
    logic [3:0]        mode;
    logic [LevelW-1:0] level_a;
    logic [PixW-1:0]   level_b;
    logic [PixW-1:0]   color_r;
    logic [PixW-1:0]   color_g;
    logic [PixW-1:0]   color_b;
  } cfg_t;

  typedef struct packed {
    result_t         simple;
    logic [PixW-1:0] dr;
    logic [PixW-1:0] dg;
    logic [PixW-1:0] db;
    logic [SumW-1:0] rgb_sum;
  } s1_t;

  typedef struct packed {
    result_t         simple;
    logic [SqW-1:0]  sq_r;
    logic [SqW-1:0]  sq_g;
    logic [SqW-1:0]  sq_b;
    logic [SumW-1:0] l1;
    logic [PixW-1:0] quot;
  } s2_t;

endpackage

`default_nettype wire

/* hw/rtl/ppo_front.sv */
// ----------------------------------------------------------------------------
// ppo_front
// first stage: simple point ops, channel differences and channel sum
// ----------------------------------------------------------------------------
`default_nettype none

module ppo_front import ppo_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   vin,
  input  pixel_t pixel,
  input  cfg_t   cfg,
  output logic   vout,
  output s1_t    word
);

  s1_t word_next;

  function automatic logic [PixW-1:0] abs_diff(input logic [PixW-1:0] a,
                                               input logic [PixW-1:0] b);
    abs_diff = (a > b) ? a - b : b - a;
  endfunction

  function automatic logic [PixW-1:0] sat_add(input logic [PixW-1:0] a,
                                              input logic [PixW-1:0] b);
    logic [PixW:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = s[PixW] ? PIX_MAX : s[PixW-1:0];
  endfunction

  always_comb begin
    logic [LevelW:0] gsum;
    gsum = {{(LevelW+1-PixW){1'b0}}, pixel.gray_in} + {1'b0, cfg.level_a};
    word_next.simple.red_out       = pixel.red_in;
    word_next.simple.green_out     = pixel.green_in;
    word_next.simple.blue_out      = pixel.blue_in;
    word_next.simple.gray_out      = pixel.gray_in;
    word_next.simple.frame_end_out = pixel.frame_end_in;
    unique case (cfg.mode)
      MODE_THR: begin
        word_next.simple.gray_out =
          ({{(LevelW-PixW){1'b0}}, pixel.gray_in} < cfg.level_a) ? PIX_MAX : '0;
      end
      MODE_BAND: begin
        word_next.simple.gray_out =
          (({{(LevelW-PixW){1'b0}}, pixel.gray_in} > cfg.level_a) &&
           (pixel.gray_in < cfg.level_b)) ? PIX_MAX : '0;
      end
      MODE_INV_GRAY: word_next.simple.gray_out = PIX_MAX - pixel.gray_in;
      MODE_ADD_GRAY: begin
        word_next.simple.gray_out = (gsum > {{(LevelW+1-PixW){1'b0}}, PIX_MAX}) ?
                                    PIX_MAX : gsum[PixW-1:0];
      end
      MODE_INV_COLOR: begin
        word_next.simple.red_out   = PIX_MAX - pixel.red_in;
        word_next.simple.green_out = PIX_MAX - pixel.green_in;
        word_next.simple.blue_out  = PIX_MAX - pixel.blue_in;
      end
      MODE_ADD_COLOR: begin
        word_next.simple.red_out   = sat_add(pixel.red_in, cfg.color_r);
        word_next.simple.green_out = sat_add(pixel.green_in, cfg.color_g);
        word_next.simple.blue_out  = sat_add(pixel.blue_in, cfg.color_b);
      end
      default: ;
    endcase
    word_next.dr = abs_diff(pixel.red_in, cfg.color_r);
    word_next.dg = abs_diff(pixel.green_in, cfg.color_g);
    word_next.db = abs_diff(pixel.blue_in, cfg.color_b);
    word_next.rgb_sum = {2'b00, pixel.red_in} + {2'b00, pixel.green_in} +
                        {2'b00, pixel.blue_in};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

`default_nettype wire

/* hw/rtl/ppo_mid.sv */
// ----------------------------------------------------------------------------
// ppo_mid
// second stage: squared differences, L1 distance and divide by three
// ----------------------------------------------------------------------------
`default_nettype none

module ppo_mid import ppo_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic vin,
  input  s1_t  win,
  output logic vout,
  output s2_t  word
);

  s2_t              word_next;
  logic [Div3W-1:0] prod;

  assign prod = {{(Div3W-SumW){1'b0}}, win.rgb_sum} *
                {{(Div3W-SumW){1'b0}}, DIV3_MUL};

  always_comb begin
    word_next.simple = win.simple;
    word_next.sq_r   = {{PixW{1'b0}}, win.dr} * {{PixW{1'b0}}, win.dr};
    word_next.sq_g   = {{PixW{1'b0}}, win.dg} * {{PixW{1'b0}}, win.dg};
    word_next.sq_b   = {{PixW{1'b0}}, win.db} * {{PixW{1'b0}}, win.db};
    word_next.l1     = {2'b00, win.dr} + {2'b00, win.dg} + {2'b00, win.db};
    word_next.quot   = prod[DIV3_SHIFT +: PixW];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

`default_nettype wire

/* hw/rtl/ppo_back.sv */
// ----------------------------------------------------------------------------
// ppo_back
// last stage: distance compares and final mode select into the output word
// ----------------------------------------------------------------------------
`default_nettype none

module ppo_back import ppo_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              vin,
  input  s2_t               win,
  input  cfg_t              cfg,
  input  logic [LvlSqW-1:0] level_sq,
  output logic              done,
  output result_t           result
);

  result_t           result_next;
  logic [SqSumW-1:0] l2;
  logic              near;

  assign l2 = {2'b00, win.sq_r} + {2'b00, win.sq_g} + {2'b00, win.sq_b};

  always_comb begin
    near        = 1'b0;
    result_next = win.simple;
    unique case (cfg.mode)
      MODE_TO_GRAY: result_next.gray_out = win.quot;
      MODE_L1: begin
        near = win.l1 < cfg.level_a;
        result_next.red_out   = near ? '0 : PIX_MAX;
        result_next.green_out = near ? '0 : PIX_MAX;
        result_next.blue_out  = near ? '0 : PIX_MAX;
      end
      MODE_L2: begin
        near = {{(LvlSqW-SqSumW){1'b0}}, l2} < level_sq;
        result_next.red_out   = near ? '0 : PIX_MAX;
        result_next.green_out = near ? '0 : PIX_MAX;
        result_next.blue_out  = near ? '0 : PIX_MAX;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vin;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

`ifndef SYNTHESIS
  a_key_black_white: assert property (@(posedge clk) disable iff (rst)
    (done && ($past(cfg.mode) == MODE_L1 || $past(cfg.mode) == MODE_L2)) |->
    (result.red_out == result.green_out && result.green_out == result.blue_out &&
     (result.red_out == '0 || result.red_out == PIX_MAX)))
    else $error("colour key word is not pure black or white");
`endif

endmodule

`default_nettype wire

/* hw/rtl/pixel_point_operation_unit.sv */
// ----------------------------------------------------------------------------
// pixel_point_operation_unit
// per-pixel point operations: thresholds, inversion, saturating adds,
// rgb to gray and colour-key distance, in a three-stage pipeline
//
//   channel   ports                          handshake
//   input     start, busy, pixel             taken when start && !busy
//   output    done, result                   one-cycle strobe, no back-pressure
//   config    cfg_we, cfg_index, cfg_data    write when cfg_we, no wait
//
// start passes through the front, mid and back stage registers to done, one word per cycle sustained
// depth is set by the square and divide-by-three multipliers in stage two
// busy is always low: every stage advances each cycle
// rst clears the valid bits and the config registers to their reset values
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_point_operation_unit import ppo_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  pixel_t          pixel,
  output logic            done,
  output result_t         result,
  input  logic            cfg_we,
  input  logic [IdxW-1:0] cfg_index,
  input  logic [CfgW-1:0] cfg_data
);

  cfg_t              cfg;
  logic [LvlSqW-1:0] level_sq;
  logic              v1;
  logic              v2;
  s1_t               w1;
  s2_t               w2;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode    <= MODE_THR;
      cfg.level_a <= '0;
      cfg.level_b <= PIX_MAX;
      cfg.color_r <= '0;
      cfg.color_g <= '0;
      cfg.color_b <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:    cfg.mode    <= cfg_data[3:0];
        REG_LEVEL_A: cfg.level_a <= cfg_data[LevelW-1:0];
        REG_LEVEL_B: cfg.level_b <= cfg_data[PixW-1:0];
        REG_COLOR_R: cfg.color_r <= cfg_data[PixW-1:0];
        REG_COLOR_G: cfg.color_g <= cfg_data[PixW-1:0];
        REG_COLOR_B: cfg.color_b <= cfg_data[PixW-1:0];
        default: ;
      endcase
    end
  end

  // squared level, registered and used in the back stage
  always_ff @(posedge clk) begin
    if (rst) begin
      level_sq <= '0;
    end else begin
      level_sq <= {{(LvlSqW-LevelW){1'b0}}, cfg.level_a} *
                  {{(LvlSqW-LevelW){1'b0}}, cfg.level_a};
    end
  end

  ppo_front u_front (
    .clk   (clk),
    .rst   (rst),
    .vin   (start && !busy),
    .pixel (pixel),
    .cfg   (cfg),
    .vout  (v1),
    .word  (w1)
  );

  ppo_mid u_mid (
    .clk  (clk),
    .rst  (rst),
    .vin  (v1),
    .win  (w1),
    .vout (v2),
    .word (w2)
  );

  ppo_back u_back (
    .clk      (clk),
    .rst      (rst),
    .vin      (v2),
    .win      (w2),
    .cfg      (cfg),
    .level_sq (level_sq),
    .done     (done),
    .result   (result)
  );

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$past(rst, 2) && !$past(rst, 3)) |-> (done == $past(start, 3)))
    else $error("done does not follow start by three cycles");

  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    (done && !$past(rst) && !$past(rst, 2) && !$past(rst, 3)) |->
    (result.frame_end_out == $past(pixel.frame_end_in, 3)))
    else $error("frame end mark lost in pipeline");

  a_empty_after_reset: assert property (@(posedge clk)
    $fell(rst) |-> (!done && !v1 && !v2))
    else $error("pipeline holds a word after reset");
`endif

endmodule

`default_nettype wire

/* tb/pixel_point_operation_unit_test.sv */
// ----------------------------------------------------------------------------
// pixel_point_operation_unit_test
// self-checking bench for the pixel point operation unit: a short directed
// pass over every mode and the corner cases, then random register settings
// with random pixel words sent in bursts; every result word is checked
// field by field against a predictor of the point operations
// ----------------------------------------------------------------------------
module pixel_point_operation_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ppo_pkg::*;

  localparam int RANDOM_ITEMS = 1700;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;

  localparam logic [3:0]      MODE_SPARE_LO = 4'd9;
  localparam logic [3:0]      MODE_SPARE_HI = 4'd15;
  localparam logic [IdxW-1:0] REG_SPARE_LO  = 3'd6;
  localparam logic [IdxW-1:0] REG_SPARE_HI  = 3'd7;

  logic            clk       = 1'b0;
  logic            rst       = 1'b1;
  logic            start     = 1'b0;
  logic            cfg_we    = 1'b0;
  logic [IdxW-1:0] cfg_index = '0;
  logic [CfgW-1:0] cfg_data  = '0;
  pixel_t          pixel     = '0;
  logic            busy;
  logic            done;
  result_t         result;

  pixel_t  pending_px[$];
  result_t expected_px[$];
  cfg_t    cfg_model;
  int      errors      = 0;
  int      burst_left  = 0;
  int      gap_left    = 0;
  bit      draining    = 1'b0;
  int      idle_cycles = 0;

  pixel_point_operation_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .pixel     (pixel),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int unsigned abs_diff8(logic [PixW-1:0] a, logic [PixW-1:0] b);
    return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
  endfunction

  function automatic logic [PixW-1:0] sat8(int unsigned v);
    return (v > PIX_MAX) ? PIX_MAX : PixW'(v);
  endfunction

  function automatic result_t predict_px(pixel_t p);
    result_t     r;
    int unsigned dr;
    int unsigned dg;
    int unsigned db;
    bit          close;
    r.red_out       = p.red_in;
    r.green_out     = p.green_in;
    r.blue_out      = p.blue_in;
    r.gray_out      = p.gray_in;
    r.frame_end_out = p.frame_end_in;
    dr = abs_diff8(p.red_in, cfg_model.color_r);
    dg = abs_diff8(p.green_in, cfg_model.color_g);
    db = abs_diff8(p.blue_in, cfg_model.color_b);
    case (cfg_model.mode)
      MODE_THR: begin
        r.gray_out = (p.gray_in < cfg_model.level_a) ? PIX_MAX : '0;
      end
      MODE_BAND: begin
        r.gray_out = (p.gray_in > cfg_model.level_a && p.gray_in < cfg_model.level_b) ?
                     PIX_MAX : '0;
      end
      MODE_INV_GRAY: r.gray_out = PIX_MAX - p.gray_in;
      MODE_ADD_GRAY: r.gray_out = sat8(int'(p.gray_in) + int'(cfg_model.level_a));
      MODE_INV_COLOR: begin
        r.red_out   = PIX_MAX - p.red_in;
        r.green_out = PIX_MAX - p.green_in;
        r.blue_out  = PIX_MAX - p.blue_in;
      end
      MODE_ADD_COLOR: begin
        r.red_out   = sat8(int'(p.red_in) + int'(cfg_model.color_r));
        r.green_out = sat8(int'(p.green_in) + int'(cfg_model.color_g));
        r.blue_out  = sat8(int'(p.blue_in) + int'(cfg_model.color_b));
      end
      MODE_TO_GRAY: begin
        r.gray_out = PixW'((int'(p.red_in) + int'(p.green_in) + int'(p.blue_in)) / 3);
      end
      MODE_L1, MODE_L2: begin
        if (cfg_model.mode == MODE_L1) begin
          close = (dr + dg + db) < int'(cfg_model.level_a);
        end else begin
          close = (dr * dr + dg * dg + db * db) <
                  int'(cfg_model.level_a) * int'(cfg_model.level_a);
        end
        r.red_out   = close ? '0 : PIX_MAX;
        r.green_out = close ? '0 : PIX_MAX;
        r.blue_out  = close ? '0 : PIX_MAX;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic pixel_t make_px(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                     logic [7:0] y, logic fe);
    pixel_t p;
    p.red_in       = r;
    p.green_in     = g;
    p.blue_in      = b;
    p.gray_in      = y;
    p.frame_end_in = fe;
    return p;
  endfunction

  function automatic logic [PixW-1:0] clip8(int v);
    return (v < 0) ? '0 : (v > 255) ? PIX_MAX : PixW'(v);
  endfunction

  function automatic logic [PixW-1:0] pick8();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return PIX_MAX;
      default: return PixW'($urandom);
    endcase
  endfunction

  function automatic logic [LevelW-1:0] pick_level(logic [3:0] m);
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 10'd1023 : 10'd0;
    if ($urandom_range(0, 15) == 0) return LevelW'($urandom_range(0, 1023));
    case (m)
      MODE_L1: return LevelW'($urandom_range(0, 150));
      MODE_L2: return LevelW'($urandom_range(0, 100));
      MODE_ADD_GRAY: return LevelW'($urandom_range(0, 300));
      default: return LevelW'($urandom_range(0, 260));
    endcase
  endfunction

  task automatic note_error(string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_field(string name, logic [PixW-1:0] got, logic [PixW-1:0] want);
    if (got !== want) begin
      note_error($sformatf("%s got %0h want %0h", name, got, want));
    end
  endtask

  task automatic write_reg(logic [IdxW-1:0] idx, logic [CfgW-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_MODE:    cfg_model.mode    = data[3:0];
      REG_LEVEL_A: cfg_model.level_a = data[LevelW-1:0];
      REG_LEVEL_B: cfg_model.level_b = data[PixW-1:0];
      REG_COLOR_R: cfg_model.color_r = data[PixW-1:0];
      REG_COLOR_G: cfg_model.color_g = data[PixW-1:0];
      REG_COLOR_B: cfg_model.color_b = data[PixW-1:0];
      default: ;
    endcase
  endtask

  // upper data bits are random, the block keeps only the register width
  task automatic program_regs(logic [3:0] m, logic [LevelW-1:0] la, logic [7:0] lb,
                              logic [7:0] cr, logic [7:0] cg, logic [7:0] cb);
    write_reg(REG_SPARE_LO, CfgW'($urandom));
    write_reg(REG_MODE, {6'($urandom), m});
    write_reg(REG_LEVEL_A, la);
    write_reg(REG_LEVEL_B, {2'($urandom), lb});
    write_reg(REG_COLOR_R, {2'($urandom), cr});
    write_reg(REG_COLOR_G, {2'($urandom), cg});
    write_reg(REG_COLOR_B, {2'($urandom), cb});
    write_reg(REG_SPARE_HI, CfgW'($urandom));
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pending_px.size() != 0 || start || expected_px.size() != 0) @(negedge clk);
  endtask

  task automatic add_random_items(int n);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] y;
    logic       fe;
    for (int i = 0; i < n; i++) begin
      r  = PixW'($urandom);
      g  = PixW'($urandom);
      b  = PixW'($urandom);
      y  = PixW'($urandom);
      fe = ($urandom_range(0, 15) == 0);
      if ((cfg_model.mode == MODE_L1 || cfg_model.mode == MODE_L2) &&
          $urandom_range(0, 9) < 6) begin
        r = clip8(int'(cfg_model.color_r) + int'($urandom_range(0, 80)) - 40);
        g = clip8(int'(cfg_model.color_g) + int'($urandom_range(0, 80)) - 40);
        b = clip8(int'(cfg_model.color_b) + int'($urandom_range(0, 80)) - 40);
      end
      if ((cfg_model.mode == MODE_THR || cfg_model.mode == MODE_BAND) &&
          $urandom_range(0, 1) == 0) begin
        if (cfg_model.mode == MODE_BAND && $urandom_range(0, 1) == 0) begin
          y = clip8(int'(cfg_model.level_b) + int'($urandom_range(0, 6)) - 3);
        end else begin
          y = clip8(int'(cfg_model.level_a) + int'($urandom_range(0, 6)) - 3);
        end
      end
      pending_px.push_back(make_px(r, g, b, y, fe));
    end
  endtask

  // sender: bursts of words with gaps, now and then held until all results are back
  always @(posedge clk) begin
    if (rst) begin
      start      <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
      draining   = 1'b0;
    end else begin
      if (start && !busy) begin
        expected_px.push_back(predict_px(pixel));
      end
      if (start && busy) begin
      end else if (gap_left != 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (draining && expected_px.size() != 0) begin
        start <= 1'b0;
      end else if (pending_px.size() != 0) begin
        draining = 1'b0;
        pixel <= pending_px.pop_front();
        start <= 1'b1;
        if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150) :
                       $urandom_range(1, 20);
          gap_left   = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
          draining   = ($urandom_range(0, 9) == 0);
        end else begin
          burst_left--;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && done === 1'b1) begin
      if (expected_px.size() == 0) begin
        note_error("result word with nothing expected");
      end else begin
        want = expected_px.pop_front();
        check_field("red_out", result.red_out, want.red_out);
        check_field("green_out", result.green_out, want.green_out);
        check_field("blue_out", result.blue_out, want.blue_out);
        check_field("gray_out", result.gray_out, want.gray_out);
        check_field("frame_end_out", result.frame_end_out, want.frame_end_out);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done === 1'b1) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int         sent;
    int         n;
    logic [3:0] m;
    cfg_model = '{mode: MODE_THR, level_a: '0, level_b: PIX_MAX,
                  color_r: '0, color_g: '0, color_b: '0};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // registers at their reset values
    pending_px.push_back(make_px(8'd37, 8'd200, 8'd5, 8'd0, 1'b0));
    wait_idle();

    program_regs(MODE_THR, 10'd128, 8'd255, 8'd0, 8'd0, 8'd0);
    pending_px.push_back(make_px(8'd1, 8'd2, 8'd3, 8'd127, 1'b0));
    pending_px.push_back(make_px(8'd1, 8'd2, 8'd3, 8'd128, 1'b1));
    wait_idle();

    program_regs(MODE_BAND, 10'd10, 8'd200, 8'd0, 8'd0, 8'd0);
    pending_px.push_back(make_px(8'd0, 8'd0, 8'd0, 8'd11, 1'b0));
    pending_px.push_back(make_px(8'd0, 8'd0, 8'd0, 8'd200, 1'b1));
    pending_px.push_back(make_px(8'd0, 8'd0, 8'd0, 8'd10, 1'b0));
    wait_idle();

    // crossed band bounds
    program_regs(MODE_BAND, 10'd200, 8'd100, 8'd0, 8'd0, 8'd0);
    pending_px.push_back(make_px(8'd9, 8'd9, 8'd9, 8'd150, 1'b0));
    wait_idle();

    program_regs(MODE_INV_GRAY, 10'd0, 8'd255, 8'd0, 8'd0, 8'd0);
    pending_px.push_back(make_px(8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
    pending_px.push_back(make_px(8'd255, 8'd255, 8'd255, 8'd255, 1'b1));
    wait_idle();

    // gray offset above the pixel range
    program_regs(MODE_ADD_GRAY, 10'd1023, 8'd255, 8'd0, 8'd0, 8'd0);
    pending_px.push_back(make_px(8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
    pending_px.push_back(make_px(8'd255, 8'd255, 8'd255, 8'd255, 1'b1));
    wait_idle();

    program_regs(MODE_INV_COLOR, 10'd0, 8'd255, 8'd0, 8'd0, 8'd0);
    pending_px.push_back(make_px(8'd0, 8'd0, 8'd0, 8'd0, 1'b1));
    pending_px.push_back(make_px(8'd255, 8'd255, 8'd255, 8'd255, 1'b0));
    wait_idle();

    program_regs(MODE_ADD_COLOR, 10'd0, 8'd255, 8'd255, 8'd1, 8'd0);
    pending_px.push_back(make_px(8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
    pending_px.push_back(make_px(8'd255, 8'd254, 8'd255, 8'd255, 1'b1));
    wait_idle();

    program_regs(MODE_TO_GRAY, 10'd0, 8'd255, 8'd0, 8'd0, 8'd0);
    pending_px.push_back(make_px(8'd255, 8'd255, 8'd255, 8'd0, 1'b0));
    pending_px.push_back(make_px(8'd1, 8'd1, 8'd0, 8'd255, 1'b1));
    wait_idle();

    program_regs(MODE_L1, 10'd1023, 8'd255, 8'd255, 8'd0, 8'd128);
    pending_px.push_back(make_px(8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
    pending_px.push_back(make_px(8'd255, 8'd0, 8'd128, 8'd77, 1'b1));
    wait_idle();

    // zero distance against a zero level is not below it
    program_regs(MODE_L2, 10'd0, 8'd255, 8'd12, 8'd34, 8'd56);
    pending_px.push_back(make_px(8'd12, 8'd34, 8'd56, 8'd0, 1'b0));
    wait_idle();

    program_regs(MODE_L2, 10'd1023, 8'd255, 8'd255, 8'd255, 8'd255);
    pending_px.push_back(make_px(8'd0, 8'd0, 8'd0, 8'd200, 1'b1));
    wait_idle();

    // unused mode code passes the pixel through
    program_regs(MODE_SPARE_HI, 10'd1023, 8'd0, 8'd255, 8'd255, 8'd255);
    pending_px.push_back(make_px(8'd255, 8'd255, 8'd255, 8'd255, 1'b1));
    wait_idle();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      n = $urandom_range(20, 90);
      m = ($urandom_range(0, 19) < 18) ? 4'($urandom_range(MODE_THR, MODE_L2)) :
          4'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
      program_regs(m, pick_level(m), pick8(), pick8(), pick8(), pick8());
      add_random_items(n);
      wait_idle();
      sent += n;
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_px.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* pixel_point_operation_unit.f */
hw/rtl/ppo_pkg.sv
hw/rtl/ppo_front.sv
hw/rtl/ppo_mid.sv
hw/rtl/ppo_back.sv
hw/rtl/pixel_point_operation_unit.sv
tb/pixel_point_operation_unit_test.sv
